// File: sv/cdo_pkg.sv
// Shared widths, codes, handshake structs and calendar helpers for the date-time offset block.
`timescale 1ns / 1ps
`default_nettype none
package cdo_pkg;

	// Field widths
	localparam int FRACTION_BITS = 32;
	localparam int YEAR_BITS     = 12;
	localparam int YEAR_W        = YEAR_BITS;
	localparam int MONTH_W       = 4;
	localparam int DAY_W         = 5;
	localparam int HOUR_W        = 5;
	localparam int MIN_W         = 6;
	localparam int SEC_W         = 6;
	localparam int FRAC_W        = FRACTION_BITS;
	localparam int OFS_W         = 31;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MONTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DAY   = 2'd2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SET = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD = 2'd1;
	localparam logic [OP_W-1:0] OP_SUB = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EARLY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Reset values
	localparam logic [YEAR_W-1:0]  YEAR_RST  = YEAR_W'(1980);
	localparam logic [MONTH_W-1:0] MONTH_RST = MONTH_W'(1);
	localparam logic [DAY_W-1:0]   DAY_RST   = DAY_W'(6);

	// Calendar constants
	localparam logic [YEAR_W-1:0]  YEAR_MAX     = '1;
	localparam logic [MONTH_W-1:0] MONTH_FIRST  = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_LAST   = MONTH_W'(12);
	localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_APR    = MONTH_W'(4);
	localparam logic [MONTH_W-1:0] MONTH_JUN    = MONTH_W'(6);
	localparam logic [MONTH_W-1:0] MONTH_SEP    = MONTH_W'(9);
	localparam logic [MONTH_W-1:0] MONTH_NOV    = MONTH_W'(11);
	localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
	localparam logic [HOUR_W-1:0]  HOUR_LAST    = HOUR_W'(23);
	localparam logic [MIN_W-1:0]   MINUTE_LAST  = MIN_W'(59);
	localparam logic [SEC_W-1:0]   SECOND_LAST  = SEC_W'(60);

	// Divider and work widths
	localparam int DIV_W   = 32;
	localparam int REM_W   = 6;
	localparam int WIDE_W  = DIV_W + 2;
	localparam int DAYW_W  = 18;
	localparam logic [REM_W:0] DIV_MINUTE = (REM_W+1)'(60);
	localparam logic [REM_W:0] DIV_HOUR   = (REM_W+1)'(24);

	// Reciprocals of 60 and 24: exact quotients for any 32-bit dividend
	localparam logic [DIV_W-1:0] RECIP_60 = 32'h8888_8889;
	localparam int               SHIFT_60 = 37;
	localparam logic [DIV_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
	localparam int               SHIFT_24 = 36;

	// Carry units in order
	localparam int UNIT_W = 2;
	localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
	localparam logic [UNIT_W-1:0] UNIT_MIN  = 2'd1;
	localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;

	// Reciprocal of 25 for the century test: exact for quotients of up to 16-bit years
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(41944);
	localparam int QY_W = YEAR_W - 2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [YEAR_W-1:0]  set_year;
		logic [MONTH_W-1:0] set_month;
		logic [DAY_W-1:0]   set_day;
		logic [HOUR_W-1:0]  set_hour;
		logic [MIN_W-1:0]   set_minute;
		logic [SEC_W-1:0]   set_second;
		logic [FRAC_W-1:0]  set_fraction;
		logic [OFS_W-1:0]   offset_seconds;
		logic [FRAC_W-1:0]  offset_fraction;
	} cdo_item_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year_out;
		logic [MONTH_W-1:0]  month_out;
		logic [DAY_W-1:0]    day_out;
		logic [HOUR_W-1:0]   hour_out;
		logic [MIN_W-1:0]    minute_out;
		logic [SEC_W-1:0]    second_out;
		logic [FRAC_W-1:0]   fraction_out;
		logic [STATUS_W-1:0] status;
	} cdo_result_t;

	typedef struct packed {
		logic              capture;
		logic              set_load;
		logic              start;
		logic              load;
		logic              div_step;
		logic              fix;
		logic              day_load;
		logic              month_step;
		logic              commit;
		logic              out_load;
		logic [UNIT_W-1:0] unit;
	} cdo_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            month_done;
		logic            month_err;
	} cdo_stat_t;

	// Gregorian leap test; the century terms come from one multiply by 1/25
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [QY_W-1:0]           x4;
		logic [QY_W+RECIP_W-1:0]   prod;
		logic [QY_W-1:0]           q;
		logic [QY_W+4:0]           q25;
		logic [QY_W-1:0]           r;
		x4   = y[YEAR_W-1:2];
		prod = {{RECIP_W{1'b0}}, x4} * {{QY_W{1'b0}}, RECIP_25};
		q    = QY_W'(prod >> RECIP_SHIFT);
		q25  = {5'b0, q} * (QY_W+5)'(25);
		r    = x4 - q25[QY_W-1:0];
		return (y[1:0] == 2'b00) && ((r != '0) || (q[1:0] == 2'b00));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		n = DAY_W'(31);
		if (m == MONTH_FEB) begin
			n = leap ? DAY_W'(29) : DAY_W'(28);
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
			n = DAY_W'(30);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// File: sv/cdo_req_if.sv
// Input channel: one operation beat with its set and offset fields.
`timescale 1ns / 1ps
`default_nettype none
interface cdo_req_if import cdo_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [YEAR_W-1:0]  set_year;
	logic [MONTH_W-1:0] set_month;
	logic [DAY_W-1:0]   set_day;
	logic [HOUR_W-1:0]  set_hour;
	logic [MIN_W-1:0]   set_minute;
	logic [SEC_W-1:0]   set_second;
	logic [FRAC_W-1:0]  set_fraction;
	logic [OFS_W-1:0]   offset_seconds;
	logic [FRAC_W-1:0]  offset_fraction;

	modport source (output valid, operation, set_year, set_month, set_day, set_hour,
		set_minute, set_second, set_fraction, offset_seconds, offset_fraction,
		input ready);
	modport sink (input valid, operation, set_year, set_month, set_day, set_hour,
		set_minute, set_second, set_fraction, offset_seconds, offset_fraction,
		output ready);
endinterface
`default_nettype wire

// File: sv/cdo_rsp_if.sv
// Result channel: the current date and time with a status code per beat.
`timescale 1ns / 1ps
`default_nettype none
interface cdo_rsp_if import cdo_pkg::*;;
	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year_out;
	logic [MONTH_W-1:0]  month_out;
	logic [DAY_W-1:0]    day_out;
	logic [HOUR_W-1:0]   hour_out;
	logic [MIN_W-1:0]    minute_out;
	logic [SEC_W-1:0]    second_out;
	logic [FRAC_W-1:0]   fraction_out;
	logic [STATUS_W-1:0] status;

	modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
		second_out, fraction_out, status, input ready);
	modport sink (input valid, year_out, month_out, day_out, hour_out, minute_out,
		second_out, fraction_out, status, output ready);
endinterface
`default_nettype wire

// File: sv/cdo_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface cdo_cfg_if import cdo_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/cdo_dpath.sv
// Datapath: time registers, offset carry chain, shared divider and month stepper.
`timescale 1ns / 1ps
`default_nettype none
module cdo_dpath import cdo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdo_cmd_t              cmd,
	output cdo_stat_t             stat,
	input  cdo_item_t             item,
	output cdo_result_t           result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration
	logic [YEAR_W-1:0]  min_year_q;
	logic [MONTH_W-1:0] min_month_q;
	logic [DAY_W-1:0]   min_day_q;

	// Held beat and current time
	cdo_item_t          item_q;
	logic [YEAR_W-1:0]  cur_year_q;
	logic [MONTH_W-1:0] cur_month_q;
	logic [DAY_W-1:0]   cur_day_q;
	logic [HOUR_W-1:0]  cur_hour_q;
	logic [MIN_W-1:0]   cur_minute_q;
	logic [SEC_W-1:0]   cur_second_q;
	logic [FRAC_W-1:0]  cur_frac_q;
	logic [STATUS_W-1:0] status_q;
	cdo_result_t        result_q;

	// Work registers
	logic [FRAC_W-1:0]        wf_q;
	logic [DIV_W-1:0]         c_q;
	logic [DIV_W-1:0]         dvd_q;
	logic [DIV_W-1:0]         quo_q;
	logic                     neg_q;
	logic [SEC_W-1:0]         raw_q;
	logic [SEC_W-1:0]         ws_q;
	logic [MIN_W-1:0]         wmi_q;
	logic [HOUR_W-1:0]        wh_q;
	logic signed [DAYW_W-1:0] wd_q;
	logic [MONTH_W-1:0]       wmo_q;
	logic [YEAR_W-1:0]        wy_q;

	logic                     is_sub;
	logic [MONTH_W-1:0]       set_mo;
	logic [DAY_W-1:0]         set_d;
	logic [HOUR_W-1:0]        set_h;
	logic [MIN_W-1:0]         set_mi;
	logic [SEC_W-1:0]         set_s;
	logic                     early;
	logic [FRAC_W:0]          frac_sum;
	logic                     frac_borrow;
	logic [SEC_W-1:0]         base;
	logic signed [WIDE_W-1:0] base_w;
	logic signed [WIDE_W-1:0] c_w;
	logic signed [WIDE_W-1:0] v;
	logic                     v_neg;
	logic [WIDE_W-1:0]        mag;
	logic [REM_W:0]           dvs;
	logic                     hour_unit;
	logic [DIV_W-1:0]         recip;
	logic [2*DIV_W-1:0]       prod;
	logic [DIV_W-1:0]         quo_next;
	logic [2*REM_W:0]         rem_prod;
	logic [REM_W-1:0]         rem;
	logic [REM_W:0]           comp;
	logic [SEC_W-1:0]         field;
	logic [DIV_W-1:0]         carry_next;
	logic signed [DAYW_W-1:0] day_base;
	logic signed [DAYW_W-1:0] day_c;
	logic [MONTH_W-1:0]       lk_month;
	logic [YEAR_W-1:0]        lk_year;
	logic [DAY_W-1:0]         md;
	logic signed [DAYW_W-1:0] md_w;
	logic                     more;
	logic                     m_err;

	assign is_sub = (item_q.operation == OP_SUB);

	// Clamp the set fields and test against the minimum date
	always_comb begin
		set_mo = item_q.set_month;
		if (item_q.set_month < MONTH_FIRST) begin
			set_mo = MONTH_FIRST;
		end else if (item_q.set_month > MONTH_LAST) begin
			set_mo = MONTH_LAST;
		end
		set_d  = (item_q.set_day < DAY_FIRST) ? DAY_FIRST : item_q.set_day;
		set_h  = (item_q.set_hour > HOUR_LAST) ? HOUR_LAST : item_q.set_hour;
		set_mi = (item_q.set_minute > MINUTE_LAST) ? MINUTE_LAST : item_q.set_minute;
		set_s  = (item_q.set_second > SECOND_LAST) ? SECOND_LAST : item_q.set_second;
		early  = (item_q.set_year < min_year_q) ||
			((item_q.set_year == min_year_q) &&
			((set_mo < min_month_q) || ((set_mo == min_month_q) && (set_d < min_day_q))));
	end

	// Fraction sum and borrow
	assign frac_sum    = {1'b0, cur_frac_q} + {1'b0, item_q.offset_fraction};
	assign frac_borrow = (cur_frac_q < item_q.offset_fraction);

	// Pick the field of the current unit and fold in the pending carry or borrow
	always_comb begin
		unique case (cmd.unit)
			UNIT_SEC: begin
				base      = cur_second_q;
				dvs       = DIV_MINUTE;
				hour_unit = 1'b0;
			end
			UNIT_MIN: begin
				base      = cur_minute_q;
				dvs       = DIV_MINUTE;
				hour_unit = 1'b0;
			end
			default: begin
				base      = {{(SEC_W-HOUR_W){1'b0}}, cur_hour_q};
				dvs       = DIV_HOUR;
				hour_unit = 1'b1;
			end
		endcase
		base_w = $signed({{(WIDE_W-SEC_W){1'b0}}, base});
		c_w    = $signed({{(WIDE_W-DIV_W){1'b0}}, c_q});
		v      = is_sub ? (base_w - c_w) : (base_w + c_w);
		v_neg  = is_sub && v[WIDE_W-1];
		mag    = v_neg ? WIDE_W'(-v) : WIDE_W'(v);
	end

	// Quotient by reciprocal multiplication; remainder from the low bits only
	always_comb begin
		recip    = hour_unit ? RECIP_24 : RECIP_60;
		prod     = {{DIV_W{1'b0}}, dvd_q} * {{DIV_W{1'b0}}, recip};
		quo_next = hour_unit ? DIV_W'(prod >> SHIFT_24) : DIV_W'(prod >> SHIFT_60);
		rem_prod = {{(REM_W+1){1'b0}}, quo_q[REM_W-1:0]} * {{REM_W{1'b0}}, dvs};
		rem      = dvd_q[REM_W-1:0] - rem_prod[REM_W-1:0];
	end

	// Turn quotient and remainder into the field and the next carry or borrow
	always_comb begin
		comp = dvs - {1'b0, rem};
		if (!is_sub) begin
			field      = rem;
			carry_next = quo_q;
		end else if (!neg_q) begin
			field      = raw_q;
			carry_next = '0;
		end else begin
			field      = (rem == '0) ? '0 : comp[SEC_W-1:0];
			carry_next = quo_q + {{(DIV_W-1){1'b0}}, (rem != '0)};
		end
	end

	assign day_base = $signed({{(DAYW_W-DAY_W){1'b0}}, cur_day_q});
	assign day_c    = $signed({1'b0, c_q[DAYW_W-2:0]});

	// Month step: length of this month going forward, of the previous one going back
	always_comb begin
		lk_month = wmo_q;
		lk_year  = wy_q;
		if (is_sub) begin
			if (wmo_q == MONTH_FIRST) begin
				lk_month = MONTH_LAST;
				lk_year  = wy_q - YEAR_W'(1);
			end else begin
				lk_month = wmo_q - MONTH_W'(1);
			end
		end
		md   = month_days(lk_month, is_leap(lk_year));
		md_w = $signed({{(DAYW_W-DAY_W){1'b0}}, md});
		if (is_sub) begin
			more  = (wd_q < $signed(DAYW_W'(1)));
			m_err = more && (wmo_q == MONTH_FIRST) && (wy_q == '0);
		end else begin
			more  = (wd_q > md_w);
			m_err = more && (wmo_q == MONTH_LAST) && (wy_q == YEAR_MAX);
		end
	end

	assign stat.op         = item_q.operation;
	assign stat.month_done = !more;
	assign stat.month_err  = m_err;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q  <= YEAR_RST;
			min_month_q <= MONTH_RST;
			min_day_q   <= DAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_YEAR:  min_year_q  <= cfg_data[YEAR_W-1:0];
				REG_MIN_MONTH: min_month_q <= cfg_data[MONTH_W-1:0];
				REG_MIN_DAY:   min_day_q   <= cfg_data[DAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Current time and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q   <= YEAR_RST;
			cur_month_q  <= MONTH_RST;
			cur_day_q    <= DAY_RST;
			cur_hour_q   <= '0;
			cur_minute_q <= '0;
			cur_second_q <= '0;
			cur_frac_q   <= '0;
			status_q     <= ST_OK;
		end else begin
			if (cmd.capture) begin
				status_q <= ST_OK;
			end
			if (cmd.set_load) begin
				if (early) begin
					status_q <= ST_EARLY;
				end else begin
					cur_year_q   <= item_q.set_year;
					cur_month_q  <= set_mo;
					cur_day_q    <= set_d;
					cur_hour_q   <= set_h;
					cur_minute_q <= set_mi;
					cur_second_q <= set_s;
					cur_frac_q   <= item_q.set_fraction;
				end
			end
			if (cmd.month_step && m_err) begin
				status_q <= ST_RANGE;
			end
			if (cmd.commit) begin
				cur_year_q   <= wy_q;
				cur_month_q  <= wmo_q;
				cur_day_q    <= wd_q[DAY_W-1:0];
				cur_hour_q   <= wh_q;
				cur_minute_q <= wmi_q;
				cur_second_q <= ws_q;
				cur_frac_q   <= wf_q;
			end
		end
	end

	// Held beat, work registers and result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.start) begin
			if (is_sub) begin
				wf_q <= cur_frac_q - item_q.offset_fraction;
				c_q  <= {1'b0, item_q.offset_seconds} + {{(DIV_W-1){1'b0}}, frac_borrow};
			end else begin
				wf_q <= frac_sum[FRAC_W-1:0];
				c_q  <= {1'b0, item_q.offset_seconds} + {{(DIV_W-1){1'b0}}, frac_sum[FRAC_W]};
			end
		end
		if (cmd.load) begin
			dvd_q <= mag[DIV_W-1:0];
			neg_q <= v_neg;
			raw_q <= v[SEC_W-1:0];
		end
		if (cmd.div_step) begin
			quo_q <= quo_next;
		end
		if (cmd.fix) begin
			c_q <= carry_next;
			unique case (cmd.unit)
				UNIT_SEC: ws_q  <= field;
				UNIT_MIN: wmi_q <= field[MIN_W-1:0];
				default:  wh_q  <= field[HOUR_W-1:0];
			endcase
		end
		if (cmd.day_load) begin
			wd_q  <= is_sub ? (day_base - day_c) : (day_base + day_c);
			wmo_q <= cur_month_q;
			wy_q  <= cur_year_q;
		end
		if (cmd.month_step && more && !m_err) begin
			if (is_sub) begin
				wd_q  <= wd_q + md_w;
				wmo_q <= lk_month;
				wy_q  <= lk_year;
			end else begin
				wd_q <= wd_q - md_w;
				if (wmo_q == MONTH_LAST) begin
					wmo_q <= MONTH_FIRST;
					wy_q  <= wy_q + YEAR_W'(1);
				end else begin
					wmo_q <= wmo_q + MONTH_W'(1);
				end
			end
		end
		if (cmd.out_load) begin
			result_q.year_out     <= cur_year_q;
			result_q.month_out    <= cur_month_q;
			result_q.day_out      <= cur_day_q;
			result_q.hour_out     <= cur_hour_q;
			result_q.minute_out   <= cur_minute_q;
			result_q.second_out   <= cur_second_q;
			result_q.fraction_out <= cur_frac_q;
			result_q.status       <= status_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

// File: sv/cdo_ctrl.sv
// Controller: sequences set, carry-chain division, month stepping and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module cdo_ctrl import cdo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  cdo_stat_t stat,
	output cdo_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_START,
		S_LOAD,
		S_DIV,
		S_FIX,
		S_DAY,
		S_MONTH,
		S_COMMIT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [UNIT_W-1:0] unit_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.unit       = unit_q;
		cmd.capture    = (state_q == S_IDLE) && in_valid;
		cmd.set_load   = (state_q == S_DECODE) && (stat.op == OP_SET);
		cmd.start      = (state_q == S_START);
		cmd.load       = (state_q == S_LOAD);
		cmd.div_step   = (state_q == S_DIV);
		cmd.fix        = (state_q == S_FIX);
		cmd.day_load   = (state_q == S_DAY);
		cmd.month_step = (state_q == S_MONTH);
		cmd.commit     = (state_q == S_COMMIT);
		cmd.out_load   = (state_q == S_DONE) && out_free;
	end

	// State, unit and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			unit_q      <= UNIT_SEC;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid with a new result, drop it once the beat is taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (stat.op == OP_ADD || stat.op == OP_SUB) begin
						state_q <= S_START;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_START: begin
					unit_q  <= UNIT_SEC;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (unit_q == UNIT_HOUR) begin
						state_q <= S_DAY;
					end else begin
						unit_q  <= unit_q + UNIT_W'(1);
						state_q <= S_LOAD;
					end
				end
				S_DAY: begin
					state_q <= S_MONTH;
				end
				S_MONTH: begin
					// Abandon on year overflow or underflow, finish once the day fits its month
					if (stat.month_err) begin
						state_q <= S_DONE;
					end else if (stat.month_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/calendar_datetime_offset.sv
// Top level: Gregorian date-time register with second-offset add and subtract.
//
// Holds a broken-down date and time with a 0.32 binary fraction of a second and
// returns it, with a status code, for every beat taken. A set is decoded and
// loaded into the current time, then copied to the result register. Add and
// subtract first fold the fraction carry or borrow into the offset, then normalise
// seconds, minutes and hours in turn (load, one multiply by the reciprocal of
// 60 or 24, then remainder and carry), then a month stepper moves one month per
// cycle until the day fits its month. The largest offset crosses about 820 months.
// The input is taken again as soon as the result is in the output register,
// which holds it until the sink takes it. Configuration writes are taken every
// cycle.
`timescale 1ns / 1ps
`default_nettype none
module calendar_datetime_offset import cdo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cdo_req_if.sink   req,
	cdo_rsp_if.source rsp,
	cdo_cfg_if.sink   cfg
);

	cdo_cmd_t    cmd;
	cdo_stat_t   stat;
	cdo_item_t   item;
	cdo_result_t result;

	// Gather the input beat
	always_comb begin
		item.operation       = req.operation;
		item.set_year        = req.set_year;
		item.set_month       = req.set_month;
		item.set_day         = req.set_day;
		item.set_hour        = req.set_hour;
		item.set_minute      = req.set_minute;
		item.set_second      = req.set_second;
		item.set_fraction    = req.set_fraction;
		item.offset_seconds  = req.offset_seconds;
		item.offset_fraction = req.offset_fraction;
	end

	// Spread the result beat
	assign rsp.year_out     = result.year_out;
	assign rsp.month_out    = result.month_out;
	assign rsp.day_out      = result.day_out;
	assign rsp.hour_out     = result.hour_out;
	assign rsp.minute_out   = result.minute_out;
	assign rsp.second_out   = result.second_out;
	assign rsp.fraction_out = result.fraction_out;
	assign rsp.status       = result.status;

	// Configuration writes never stall
	assign cfg.ready = 1'b1;

	cdo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cdo_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data)
	);

endmodule
`default_nettype wire

// File: tb/sv/calendar_datetime_offset_chk.sv
// Checker for the date-time offset block: predicts every result beat and compares it.
`timescale 1ns / 1ps
module calendar_datetime_offset_chk import cdo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cdo_req_if   req,
	cdo_rsp_if   rsp,
	cdo_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	// Predicted date and time
	int                yr, mon, dy, hr, mn, sc;
	logic [FRAC_W-1:0] frc;

	// Minimum date accepted by a set
	int lim_yr, lim_mon, lim_dy;

	cdo_result_t datetime_q[$];
	int          faults = 0;
	int          outstanding = 0;
	int          beats_seen = 0;

	assign fail_count = faults;
	assign pending    = outstanding;

	task automatic report_fault(input string msg);
		$display("[%0t] %s", $time, msg);
		faults++;
	endtask

	task automatic compare_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want) begin
			report_fault($sformatf("result beat %0d, %s: got %0d, expected %0d",
				beats_seen, name, got, want));
		end
	endtask

	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int days_in(input int m, input int y);
		case (m)
			2: begin
				return leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Pull a negative unit up into range and return how many of the next unit it took
	function automatic longint take_borrow(inout longint v, input longint base);
		longint b;
		b = 0;
		if (v < 0) begin
			b = (-v + base - 1) / base;
			v += b * base;
		end
		return b;
	endfunction

	// Move forward: carry seconds into minutes, hours, days, then walk months
	function automatic logic [STATUS_W-1:0] advance_time(input cdo_item_t it);
		logic [FRAC_W:0] fsum;
		longint          secs, s, mi, h, d;
		int              mo, y;
		fsum = {1'b0, frc} + {1'b0, it.offset_fraction};
		secs = it.offset_seconds;
		s    = sc + secs + (fsum[FRAC_W] ? 1 : 0);
		mi   = mn + s / 60;
		s    = s % 60;
		h    = hr + mi / 60;
		mi   = mi % 60;
		d    = dy + h / 24;
		h    = h % 24;
		mo   = mon;
		y    = yr;
		while (d > days_in(mo, y)) begin
			d -= days_in(mo, y);
			mo++;
			if (mo > 12) begin
				mo = 1;
				y++;
				if (y > int'(YEAR_MAX)) begin
					return ST_RANGE;
				end
			end
		end
		frc = fsum[FRAC_W-1:0];
		sc  = int'(s);
		mn  = int'(mi);
		hr  = int'(h);
		dy  = int'(d);
		mon = mo;
		yr  = y;
		return ST_OK;
	endfunction

	// Move back: borrow down the units, then walk months back while the day is below one
	function automatic logic [STATUS_W-1:0] retreat_time(input cdo_item_t it);
		longint secs, s, mi, h, d;
		int     mo, y, borrow;
		borrow = (frc < it.offset_fraction) ? 1 : 0;
		secs   = it.offset_seconds;
		s      = sc - secs - borrow;
		mi     = mn - take_borrow(s, 60);
		h      = hr - take_borrow(mi, 60);
		d      = dy - take_borrow(h, 24);
		mo     = mon;
		y      = yr;
		while (d < 1) begin
			mo--;
			if (mo < 1) begin
				mo = 12;
				y--;
				if (y < 0) begin
					return ST_RANGE;
				end
			end
			d += days_in(mo, y);
		end
		frc = frc - it.offset_fraction;
		sc  = int'(s);
		mn  = int'(mi);
		hr  = int'(h);
		dy  = int'(d);
		mon = mo;
		yr  = y;
		return ST_OK;
	endfunction

	// Apply one operation to the predicted time and return the expected result
	function automatic cdo_result_t predict_datetime(input cdo_item_t it);
		cdo_result_t         r;
		logic [STATUS_W-1:0] st;
		int                  y, mo, d;
		st = ST_OK;
		case (it.operation)
			OP_SET: begin
				y  = int'(it.set_year);
				mo = clamp(int'(it.set_month), 1, 12);
				d  = clamp(int'(it.set_day), 1, 31);
				if (y < lim_yr || (y == lim_yr && (mo < lim_mon
						|| (mo == lim_mon && d < lim_dy)))) begin
					st = ST_EARLY;
				end else begin
					yr  = y;
					mon = mo;
					dy  = d;
					hr  = clamp(int'(it.set_hour), 0, 23);
					mn  = clamp(int'(it.set_minute), 0, 59);
					sc  = clamp(int'(it.set_second), 0, 60);
					frc = it.set_fraction;
				end
			end
			OP_ADD: begin
				st = advance_time(it);
			end
			OP_SUB: begin
				st = retreat_time(it);
			end
			default: begin
				st = ST_OK;
			end
		endcase
		r.year_out     = YEAR_W'(yr);
		r.month_out    = MONTH_W'(mon);
		r.day_out      = DAY_W'(dy);
		r.hour_out     = HOUR_W'(hr);
		r.minute_out   = MIN_W'(mn);
		r.second_out   = SEC_W'(sc);
		r.fraction_out = frc;
		r.status       = st;
		return r;
	endfunction

	// Watch all three channels on each rising edge
	always @(posedge clk or negedge arst_n) begin
		cdo_result_t got, want;
		if (!arst_n) begin
			yr      = int'(YEAR_RST);
			mon     = int'(MONTH_RST);
			dy      = int'(DAY_RST);
			hr      = 0;
			mn      = 0;
			sc      = 0;
			frc     = '0;
			lim_yr  = int'(YEAR_RST);
			lim_mon = int'(MONTH_RST);
			lim_dy  = int'(DAY_RST);
			datetime_q.delete();
			outstanding = 0;
		end else begin
			// Compare a result beat with the oldest prediction
			if (rsp.valid && rsp.ready) begin
				got = cdo_result_t'({rsp.year_out, rsp.month_out, rsp.day_out, rsp.hour_out,
					rsp.minute_out, rsp.second_out, rsp.fraction_out, rsp.status});
				if (datetime_q.size() == 0) begin
					report_fault($sformatf("result beat %0d arrived with no operation waiting",
						beats_seen));
				end else begin
					want = datetime_q.pop_front();
					compare_field("year", got.year_out, want.year_out);
					compare_field("month", got.month_out, want.month_out);
					compare_field("day", got.day_out, want.day_out);
					compare_field("hour", got.hour_out, want.hour_out);
					compare_field("minute", got.minute_out, want.minute_out);
					compare_field("second", got.second_out, want.second_out);
					compare_field("fraction", got.fraction_out, want.fraction_out);
					compare_field("status", got.status, want.status);
				end
				beats_seen++;
			end
			// Track the minimum date registers
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_YEAR: begin
						lim_yr = int'(cfg.data[YEAR_W-1:0]);
					end
					REG_MIN_MONTH: begin
						lim_mon = int'(cfg.data[MONTH_W-1:0]);
					end
					REG_MIN_DAY: begin
						lim_dy = int'(cfg.data[DAY_W-1:0]);
					end
					default: begin
					end
				endcase
			end
			// Predict the result of an accepted operation beat
			if (req.valid && req.ready) begin
				datetime_q.push_back(predict_datetime(cdo_item_t'({req.operation, req.set_year,
					req.set_month, req.set_day, req.set_hour, req.set_minute, req.set_second,
					req.set_fraction, req.offset_seconds, req.offset_fraction})));
			end
			outstanding = datetime_q.size();
		end
	end

endmodule

// File: tb/sv/calendar_datetime_offset_tb.sv
// Testbench top for the date-time offset block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module calendar_datetime_offset_tb;
	import cdo_pkg::*;

	localparam int     CLK_HALF     = 6;
	localparam int     RESET_CYCLES = 6;
	localparam int     HOLD_CYCLES  = 300;
	localparam longint CYCLE_LIMIT  = 2_500_000;

	// Operation code the block ignores
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic   clk;
	logic   arst_n;
	int     fail_count;
	int     pending;
	longint cycle_count = 0;
	bit     calm = 1'b0;
	bit     rsp_hold_req = 1'b0;
	int     lim_year = int'(YEAR_RST);

	cdo_req_if req_ch();
	cdo_rsp_if rsp_ch();
	cdo_cfg_if cfg_ch();

	calendar_datetime_offset dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	calendar_datetime_offset_chk chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("calendar_datetime_offset_tb NOT OK");
			$finish;
		end
	end

	// Random operation: add most often, set and subtract a little less, the unused code rarely
	function automatic cdo_item_t random_item();
		cdo_item_t it;
		int        pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			it.operation = OP_UNUSED;
		end else if (pick <= 6) begin
			it.operation = OP_SET;
		end else if (pick <= 13) begin
			it.operation = OP_ADD;
		end else begin
			it.operation = OP_SUB;
		end
		case ($urandom_range(0, 7))
			0: it.set_year = YEAR_W'($urandom_range(0, 4095));
			1: it.set_year = YEAR_W'(4095 - $urandom_range(0, 3));
			2: it.set_year = YEAR_W'($urandom_range(0, 3));
			3: it.set_year = YEAR_W'(lim_year + $urandom_range(0, 2) - 1);
			default: it.set_year = YEAR_W'($urandom_range(1900, 2400));
		endcase
		it.set_month  = ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom_range(0, 15))
			: MONTH_W'($urandom_range(1, 12));
		it.set_day    = ($urandom_range(0, 9) == 0) ? DAY_W'(0)
			: DAY_W'($urandom_range(1, 31));
		it.set_hour   = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom_range(0, 31))
			: HOUR_W'($urandom_range(0, 23));
		it.set_minute = ($urandom_range(0, 9) == 0) ? MIN_W'($urandom_range(0, 63))
			: MIN_W'($urandom_range(0, 59));
		it.set_second = ($urandom_range(0, 9) == 0) ? SEC_W'($urandom_range(0, 63))
			: SEC_W'($urandom_range(0, 60));
		case ($urandom_range(0, 9))
			0: it.set_fraction = '0;
			1: it.set_fraction = '1;
			default: it.set_fraction = FRAC_W'($urandom());
		endcase
		case ($urandom_range(0, 9))
			0: it.offset_seconds = '0;
			1, 2, 3: it.offset_seconds = OFS_W'($urandom_range(0, 120));
			4, 5: it.offset_seconds = OFS_W'($urandom_range(0, 200000));
			6, 7: it.offset_seconds = OFS_W'($urandom_range(0, 40000000));
			default: it.offset_seconds = OFS_W'($urandom());
		endcase
		case ($urandom_range(0, 9))
			0: it.offset_fraction = '0;
			1: it.offset_fraction = '1;
			default: it.offset_fraction = FRAC_W'($urandom());
		endcase
		return it;
	endfunction

	function automatic cdo_item_t set_item(input int y, input int mo, input int d, input int h,
			input int mi, input int s, input logic [FRAC_W-1:0] f);
		cdo_item_t it;
		it              = random_item();
		it.operation    = OP_SET;
		it.set_year     = YEAR_W'(y);
		it.set_month    = MONTH_W'(mo);
		it.set_day      = DAY_W'(d);
		it.set_hour     = HOUR_W'(h);
		it.set_minute   = MIN_W'(mi);
		it.set_second   = SEC_W'(s);
		it.set_fraction = f;
		return it;
	endfunction

	function automatic cdo_item_t shift_item(input logic [OP_W-1:0] op,
			input int unsigned secs, input logic [FRAC_W-1:0] f);
		cdo_item_t it;
		it                 = random_item();
		it.operation       = op;
		it.offset_seconds  = OFS_W'(secs);
		it.offset_fraction = f;
		return it;
	endfunction

	// Offer one operation beat after a random gap (none when calm); return at the falling edge after it is taken
	task automatic send_op(input cdo_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{req_ch.operation, req_ch.set_year, req_ch.set_month, req_ch.set_day, req_ch.set_hour,
			req_ch.set_minute, req_ch.set_second, req_ch.set_fraction, req_ch.offset_seconds,
			req_ch.offset_fraction} <= it;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic random_burst(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			send_op(random_item());
		end
	endtask

	// Drop valid and wait until every result has come back
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_DATA_W'(value);
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_minimum(input int y, input int mo, input int d);
		write_reg(REG_MIN_YEAR, y);
		write_reg(REG_MIN_MONTH, mo);
		write_reg(REG_MIN_DAY, d);
		lim_year = y;
	endtask

	// Result side: random stalls per beat, one long hold-off on request
	initial begin : rsp_side
		int hold;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				hold         = HOLD_CYCLES;
				rsp_hold_req = 1'b0;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 7);
			end
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin : stimulus
		cdo_item_t spare;
		arst_n                 = 1'b0;
		req_ch.valid           = 1'b0;
		req_ch.operation       = OP_SET;
		req_ch.set_year        = '0;
		req_ch.set_month       = '0;
		req_ch.set_day         = '0;
		req_ch.set_hour        = '0;
		req_ch.set_minute      = '0;
		req_ch.set_second      = '0;
		req_ch.set_fraction    = '0;
		req_ch.offset_seconds  = '0;
		req_ch.offset_fraction = '0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.index           = REG_MIN_YEAR;
		cfg_ch.data            = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset minimum date: boundaries, clamping, carries and wraps
		calm = 1'b1;
		send_op(shift_item(OP_ADD, 0, '0));
		send_op(set_item(1980, 1, 5, 0, 0, 0, '0));
		send_op(set_item(1979, 12, 31, 23, 59, 59, '1));
		send_op(set_item(1980, 1, 6, 0, 0, 0, '0));
		send_op(set_item(2000, 0, 0, 31, 63, 63, '1));
		send_op(set_item(2001, 15, 31, 23, 59, 60, '0));
		send_op(shift_item(OP_ADD, 0, '0));
		send_op(set_item(2001, 2, 31, 12, 0, 0, '0));
		send_op(shift_item(OP_SUB, 0, '0));
		send_op(shift_item(OP_ADD, 0, '0));
		send_op(set_item(1999, 12, 31, 23, 59, 59, '1));
		send_op(shift_item(OP_ADD, 0, FRAC_W'(1)));
		send_op(shift_item(OP_SUB, 0, FRAC_W'(1)));
		send_op(set_item(2000, 3, 1, 0, 0, 0, '0));
		send_op(shift_item(OP_SUB, 1, '0));
		send_op(set_item(2100, 3, 1, 0, 0, 0, '0));
		send_op(shift_item(OP_SUB, 1, '0));
		send_op(shift_item(OP_ADD, 32'h7fff_ffff, '1));
		send_op(shift_item(OP_SUB, 32'h7fff_ffff, '1));
		spare           = random_item();
		spare.operation = OP_UNUSED;
		send_op(spare);
		send_op(set_item(4095, 12, 31, 23, 59, 59, '0));
		send_op(shift_item(OP_ADD, 1, '0));
		settle();

		// Lowest minimum date: borrow below year zero
		write_minimum(0, 1, 1);
		send_op(set_item(0, 1, 1, 0, 0, 0, '0));
		send_op(shift_item(OP_SUB, 0, FRAC_W'(1)));
		send_op(shift_item(OP_SUB, 0, '0));
		random_burst(150);
		settle();

		// Highest minimum date: only the last day of the last year loads
		write_minimum(4095, 12, 31);
		send_op(set_item(4095, 12, 31, 23, 59, 59, '0));
		send_op(shift_item(OP_ADD, 0, '1));
		random_burst(50);
		settle();

		// Mid-range minimum with a long stall on the result side
		write_minimum(2000, 6, 15);
		rsp_hold_req = 1'b1;
		random_burst(180);
		settle();

		write_minimum($urandom_range(1900, 2100), $urandom_range(1, 12), $urandom_range(1, 31));
		random_burst(180);
		settle();
		repeat (20) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("calendar_datetime_offset_tb OK");
		end else begin
			$display("calendar_datetime_offset_tb NOT OK");
		end
		$finish;
	end

endmodule
